[rtl/ir_pulse_distance_decoder_assert.svh]
// assertion macros used by the checker of the pulse distance decoder
`ifndef IR_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipd assertion failed");

// next-cycle implication, checked outside reset
`define IPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipd assertion failed");

`endif

[rtl/ipd_pkg.sv]
// shared types and constants of the pulse distance decoder
`default_nettype none

package ipd_pkg;

  localparam int MAX_BITS = 64;
  localparam int IDX_W    = $clog2(MAX_BITS);
  localparam int COUNT_W  = $clog2(MAX_BITS + 1);
  localparam int TICK_W   = 16;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-1:0] REG_START_MIN  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_START_MAX  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_SHORT_LIM  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_ZERO_LIM   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_ONE_LIM    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT    = 3'd5;

  localparam logic [TICK_W-1:0] RST_START_MIN = 16'd1000;
  localparam logic [TICK_W-1:0] RST_START_MAX = 16'd1375;
  localparam logic [TICK_W-1:0] RST_SHORT_LIM = 16'd225;
  localparam logic [TICK_W-1:0] RST_ZERO_LIM  = 16'd375;
  localparam logic [TICK_W-1:0] RST_ONE_LIM   = 16'd625;
  localparam logic [TICK_W-1:0] RST_TIMEOUT   = 16'd1500;

  typedef struct packed {
    logic [TICK_W-1:0] start_min;
    logic [TICK_W-1:0] start_max;
    logic [TICK_W-1:0] short_lim;
    logic [TICK_W-1:0] zero_lim;
    logic [TICK_W-1:0] one_lim;
    logic [TICK_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  bit_count;
    logic [MAX_BITS-1:0] message_bits;
  } result_t;

endpackage

`default_nettype wire

[rtl/ipd_cfg_regs.sv]
// configuration register file of the pulse distance decoder
`default_nettype none

module ipd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [ipd_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic [ipd_pkg::TICK_W-1:0] cfg_wdata,
  output ipd_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_min <= ipd_pkg::RST_START_MIN;
      cfg.start_max <= ipd_pkg::RST_START_MAX;
      cfg.short_lim <= ipd_pkg::RST_SHORT_LIM;
      cfg.zero_lim  <= ipd_pkg::RST_ZERO_LIM;
      cfg.one_lim   <= ipd_pkg::RST_ONE_LIM;
      cfg.timeout   <= ipd_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_addr)
        ipd_pkg::REG_START_MIN: cfg.start_min <= cfg_wdata;
        ipd_pkg::REG_START_MAX: cfg.start_max <= cfg_wdata;
        ipd_pkg::REG_SHORT_LIM: cfg.short_lim <= cfg_wdata;
        ipd_pkg::REG_ZERO_LIM:  cfg.zero_lim  <= cfg_wdata;
        ipd_pkg::REG_ONE_LIM:   cfg.one_lim   <= cfg_wdata;
        ipd_pkg::REG_TIMEOUT:   cfg.timeout   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ipd_core.sv]
// input register, gap timer, gap classification and bit collection
`default_nettype none

module ipd_core (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ipd_pkg::cfg_t cfg,
  input  wire logic      tick_valid,
  output logic           tick_ready,
  input  wire logic      tick_edge,
  output logic           res_valid,
  input  wire logic      res_ready,
  output ipd_pkg::result_t res
);

  // input register
  logic in_valid;
  logic in_edge;

  // decoder state
  logic                          in_data;
  logic [ipd_pkg::TICK_W-1:0]    interval_count;
  logic                          counter_running;
  logic [ipd_pkg::COUNT_W-1:0]   bits_held;
  logic [ipd_pkg::MAX_BITS-1:0]  bit_store;

  logic [ipd_pkg::TICK_W-1:0]    count_inc;
  logic                          timeout_hit;
  logic                          emit;
  logic                          fire;
  logic                          start_ok;
  logic                          below_short;
  logic                          below_zero;
  logic                          below_one;
  logic                          room;
  logic [ipd_pkg::MAX_BITS-1:0]  keep_mask;

  assign count_inc   = counter_running ? interval_count + 16'd1 : interval_count;
  assign timeout_hit = counter_running && (count_inc == cfg.timeout);
  assign emit        = in_valid && !in_edge && timeout_hit && in_data;
  assign fire        = in_valid && (!emit || res_ready);
  assign tick_ready  = !in_valid || fire;

  assign start_ok    = (count_inc > cfg.start_min) && (count_inc < cfg.start_max);
  assign below_short = count_inc < cfg.short_lim;
  assign below_zero  = count_inc < cfg.zero_lim;
  assign below_one   = count_inc < cfg.one_lim;
  assign room        = bits_held < ipd_pkg::COUNT_W'(ipd_pkg::MAX_BITS);

  assign keep_mask = room ? ~({ipd_pkg::MAX_BITS{1'b1}} << bits_held)
                          : {ipd_pkg::MAX_BITS{1'b1}};

  assign res_valid        = emit;
  assign res.bit_count    = bits_held;
  assign res.message_bits = bit_store & keep_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick_ready) begin
      in_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready) begin
      in_edge <= tick_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data         <= 1'b0;
      interval_count  <= '0;
      counter_running <= 1'b0;
      bits_held       <= '0;
    end else if (fire) begin
      if (in_edge) begin
        interval_count  <= '0;
        counter_running <= 1'b1;
        if (!in_data) begin
          if (start_ok) begin
            in_data   <= 1'b1;
            bits_held <= '0;
          end
        end else if (below_short) begin
          in_data <= 1'b0;
        end else if (below_zero || below_one) begin
          if (room) begin
            bits_held <= bits_held + 1'b1;
          end
        end else begin
          in_data <= 1'b0;
        end
      end else if (timeout_hit) begin
        counter_running <= 1'b0;
        interval_count  <= '0;
      end else begin
        interval_count <= count_inc;
      end
    end
  end

  // bit store has no reset, bits above bits_held are masked on output
  always_ff @(posedge clk) begin
    if (fire && in_edge && in_data && !below_short && (below_zero || below_one) && room) begin
      bit_store[bits_held[ipd_pkg::IDX_W-1:0]] <= !below_zero;
    end
  end

endmodule

`default_nettype wire

[rtl/ipd_out_buf.sv]
// result register on the output stream
`default_nettype none

module ipd_out_buf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  output logic             res_ready,
  input  wire ipd_pkg::result_t res,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ipd_pkg::result_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/ir_pulse_distance_decoder.sv]
// the tick that ends the frame passes the input register; its result is held in the output register
// throughput: one tick per cycle unless stalled; the state update for a tick is one registered pass
// input stalls only while a finished result waits on the output and downstream is not ready
// reset: synchronous; clears the decoder state and returns all six limits to their defaults
// bit storage is not cleared; bits above the bit count are masked on output
`default_nettype none

module ir_pulse_distance_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] rising_edge, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] message_bits, [70:64] bit_count, [71] zero
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  ipd_pkg::cfg_t    cfg;
  ipd_pkg::result_t res;
  ipd_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;

  ipd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (s_axis_tvalid),
    .tick_ready (s_axis_tready),
    .tick_edge  (s_axis_tdata[0]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  ipd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.bit_count, out_res.message_bits};

endmodule

`default_nettype wire

[rtl/ipd_checker.sv]
// port-level checker of the pulse distance decoder and its bind
`default_nettype none

`include "ir_pulse_distance_decoder_assert.svh"

module ipd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  logic [6:0]  out_count;
  logic [63:0] out_bits;

  assign out_count = m_axis_tdata[70:64];
  assign out_bits  = m_axis_tdata[63:0];

  `IPD_ASSERT_NOW(a_count_range, m_axis_tvalid, out_count <= 7'd64)
  `IPD_ASSERT_NOW(a_bits_masked, m_axis_tvalid && (out_count < 7'd64), (out_bits >> out_count) == 64'd0)
  `IPD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[71] == 1'b0)
  `IPD_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (.*);

`default_nettype wire
